@@ rtl/core/m7ta_pkg.sv @@
// Shared widths, reset values, register codes and pipeline record types for the texel address block.
package m7ta_pkg;

   // Request and result field widths.
   localparam int Z_W       = 7;
   localparam int X_W       = 8;
   localparam int FRAME_W   = 17;
   localparam int TEXEL_W   = 15;

   // Configuration register widths and reset values.
   localparam int PHASE_W   = 20;
   localparam int NEAR_W    = 8;
   localparam int NUMER_W   = 16;
   localparam logic [PHASE_W-1:0] PHASE_RESET = 20'd0;
   localparam logic [NEAR_W-1:0]  NEAR_RESET  = 8'd10;
   localparam logic [NUMER_W-1:0] LAND_RESET  = 16'd7000;
   localparam logic [NUMER_W-1:0] SKY_RESET   = 16'd2048;

   // Register port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Divider operand widths: 2*depth+near fits 9 bits, depth+1 fits 8 bits.
   localparam int DU_W = 9;
   localparam int DV_W = 8;

   // Forward texel before the wrap: 16-bit quotient plus 12-bit integer phase.
   localparam int AV_W = 17;

   localparam int LAND_PHASE_SHIFT = 8;
   localparam int SKY_PHASE_SHIFT  = 13;
   localparam int SKY_U_SHIFT      = 2;

   typedef enum logic [1:0] {
      REG_SCROLL_PHASE    = 2'd0,
      REG_NEAR_HALF_WIDTH = 2'd1,
      REG_LAND_NUMERATOR  = 2'd2,
      REG_SKY_NUMERATOR   = 2'd3
   } reg_index_type;

   // Request attributes that ride alongside the dividers.
   typedef struct packed {
      logic           sky;
      logic           bad;
      logic [Z_W-1:0] depth;
      logic [X_W-1:0] column;
   } side_type;

   // What remains of a request once the framebuffer addresses are known.
   typedef struct packed {
      logic               sky;
      logic               bad;
      logic [FRAME_W-1:0] frame_right;
      logic [FRAME_W-1:0] frame_left;
   } post_type;

endpackage

@@ rtl/core/m7ta_div_pipe.sv @@
// Pipelined restoring divider, a fixed number of quotient bits per stage.
module m7ta_div_pipe #(
   parameter int NUM_W  = 16,
   parameter int DEN_W  = 8,
   parameter int STAGES = 4
) (
   input  logic              clock,
   input  logic [STAGES-1:0] en,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic [NUM_W-1:0]  quo
);

   localparam int BPS   = (NUM_W + STAGES - 1) / STAGES;
   localparam int PAD_W = BPS * STAGES;

   // The work word shifts dividend bits out at the top and quotient bits in at the bottom.
   logic [DEN_W-1:0] rem_ff   [STAGES];
   logic [DEN_W-1:0] rem_in   [STAGES];
   logic [PAD_W-1:0] work_ff  [STAGES];
   logic [PAD_W-1:0] work_in  [STAGES];
   logic [DEN_W-1:0] den_ff   [STAGES];
   logic [DEN_W-1:0] rem_src  [STAGES];
   logic [PAD_W-1:0] work_src [STAGES];
   logic [DEN_W-1:0] den_src  [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign rem_src[s]  = '0;
         assign work_src[s] = PAD_W'(num);
         assign den_src[s]  = den;
      end else begin : g_next
         assign rem_src[s]  = rem_ff[s-1];
         assign work_src[s] = work_ff[s-1];
         assign den_src[s]  = den_ff[s-1];
      end

      always_comb begin : step
         logic [DEN_W:0]   t;
         logic [DEN_W-1:0] r;
         logic [PAD_W-1:0] w;
         r = rem_src[s];
         w = work_src[s];
         for (int k = 0; k < BPS; k++) begin
            t = {r, w[PAD_W-1]};
            w = {w[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, den_src[s]}) begin
               t    = t - {1'b0, den_src[s]};
               w[0] = 1'b1;
            end
            r = t[DEN_W-1:0];
         end
         rem_in[s]  = r;
         work_in[s] = w;
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in[s];
            work_ff[s] <= work_in[s];
            den_ff[s]  <= den_src[s];
         end
      end
   end

   assign quo = work_ff[STAGES-1][NUM_W-1:0];

endmodule

@@ rtl/core/m7ta_mod_const.sv @@
// Three-stage remainder by a constant modulus through a scaled reciprocal.
module m7ta_mod_const #(
   parameter int A_W     = 17,
   parameter int MODULUS = 128
) (
   input  logic                         clock,
   input  logic [2:0]                   en,
   input  logic [A_W-1:0]               a,
   output logic [$clog2(MODULUS)-1:0]   r
);

   localparam int M_W = $clog2(MODULUS);
   localparam int SH  = A_W + M_W;
   localparam int R_W = A_W + 1;
   localparam int P_W = A_W + R_W;
   localparam int Q_W = P_W - SH;
   // Rounded-up reciprocal; with this shift the quotient is exact for every A_W-bit value.
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);

   logic [A_W-1:0] a1_ff;
   logic [P_W-1:0] prod_ff;
   logic [A_W-1:0] a2_ff;
   logic [A_W-1:0] qm_ff;
   logic [A_W-1:0] qm_in;
   logic [M_W-1:0] r_ff;

   assign qm_in = A_W'(32'(prod_ff[P_W-1:SH]) * 32'(MODULUS));

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a1_ff   <= a;
         prod_ff <= {{R_W{1'b0}}, a} * P_W'(R_W'(RECIP));
      end
      if (en[1]) begin
         a2_ff <= a1_ff;
         qm_ff <= qm_in;
      end
      if (en[2]) begin
         r_ff <= M_W'(a2_ff - qm_ff);
      end
   end

   assign r = r_ff;

endmodule

@@ rtl/core/mode7_dual_plane_texel_address_top.sv @@
// Top level of the dual-plane perspective texel address generator.
//
// Each request transaction names one mirrored pixel pair: a plane (land below the horizon,
// sky above it), a depth in rows from the horizon and a column offset from the screen
// center. The response transaction carries both framebuffer addresses, both atlas texel
// addresses and a flag for a rejected request, whose addresses all read as zero.
// The register port sets the scroll phase, the near half-width and the two depth numerators;
// the user must see that it is written only while no transaction is in flight (not enforced).
//
// The block accepts one request every clock while the response side does not stall and
// returns results in order. The pipeline runs through one input stage, one stage per four
// quotient bits of the two restoring dividers, a stage that forms the framebuffer addresses
// and the unwrapped texels, three stages of reciprocal wrap, and the output register.
// Every stage has its own valid bit; a stage moves when it is empty or its successor moves,
// so a stalled response holds in place while bubbles ahead of it still fill.
// Reset, synchronous and active high, empties the pipeline and loads the register defaults.
module mode7_dual_plane_texel_address_top #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240,
   parameter int MAP_SIZE      = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_plane_select,
   input  logic [m7ta_pkg::Z_W-1:0]          req_depth,
   input  logic [m7ta_pkg::X_W-1:0]          req_column,
   // Response channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [m7ta_pkg::FRAME_W-1:0]      rsp_frame_addr_right,
   output logic [m7ta_pkg::FRAME_W-1:0]      rsp_frame_addr_left,
   output logic [m7ta_pkg::TEXEL_W-1:0]      rsp_texel_addr_right,
   output logic [m7ta_pkg::TEXEL_W-1:0]      rsp_texel_addr_left,
   output logic                              rsp_request_bad,
   // Register port.
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [m7ta_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [m7ta_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [m7ta_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   import m7ta_pkg::*;

   localparam int MIDX  = SCREEN_WIDTH / 2;
   localparam int VIEW  = SCREEN_HEIGHT / 2;
   localparam int MAP_W = $clog2(MAP_SIZE);
   localparam int ROW_W = $clog2(VIEW + 2**Z_W + 1);
   // The horizontal numerator column*(W/2) and its quotient.
   localparam int NU_W  = $clog2((2**X_W - 1) * MIDX + 1);
   localparam int DIV_W = (NU_W > NUMER_W) ? NU_W : NUMER_W;
   localparam int DIV_STAGES = (DIV_W + 3) / 4;
   // Stage positions along the pipeline.
   localparam int ST_PREP = DIV_STAGES + 1;
   localparam int ST_MOD0 = DIV_STAGES + 2;
   localparam int ST_OUT  = DIV_STAGES + 5;
   localparam int N_ST    = DIV_STAGES + 6;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [PHASE_W-1:0] phase_ff;
   logic [NEAR_W-1:0]  near_ff;
   logic [NUMER_W-1:0] land_num_ff;
   logic [NUMER_W-1:0] sky_num_ff;
   logic               csr_write;
   reg_index_type      csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_RESET;
         near_ff     <= NEAR_RESET;
         land_num_ff <= LAND_RESET;
         sky_num_ff  <= SKY_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SCROLL_PHASE:    phase_ff    <= pwdata[PHASE_W-1:0];
            REG_NEAR_HALF_WIDTH: near_ff     <= pwdata[NEAR_W-1:0];
            REG_LAND_NUMERATOR:  land_num_ff <= pwdata[NUMER_W-1:0];
            REG_SKY_NUMERATOR:   sky_num_ff  <= pwdata[NUMER_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SCROLL_PHASE:    prdata = CSR_DATA_W'(phase_ff);
         REG_NEAR_HALF_WIDTH: prdata = CSR_DATA_W'(near_ff);
         REG_LAND_NUMERATOR:  prdata = CSR_DATA_W'(land_num_ff);
         REG_SKY_NUMERATOR:   prdata = CSR_DATA_W'(sky_num_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. A stage loads whenever it is empty or the stage after it is
   // moving on; the output register moves when the receiver does not stall.
   // ------------------------------------------------------------------
   logic [N_ST-1:0] valid_ff;
   logic [N_ST:0]   ready;

   always_comb begin
      ready[N_ST] = !rsp_stall;
      for (int i = N_ST - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < N_ST; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[N_ST-1];

   // ------------------------------------------------------------------
   // Input stage: range check and divider operands.
   // ------------------------------------------------------------------
   side_type           side_in;
   logic [NEAR_W-1:0]  near_eff;
   logic [NU_W-1:0]    nu_in;
   logic [DU_W-1:0]    du_in;
   logic [NUMER_W-1:0] nv_in;
   logic [DV_W-1:0]    dv_in;

   // A near half-width of zero acts as one so that the divisor never vanishes.
   assign near_eff = (near_ff == '0) ? NEAR_W'(1) : near_ff;

   always_comb begin
      side_in.sky    = req_plane_select;
      side_in.depth  = req_depth;
      side_in.column = req_column;
      if (req_plane_select) begin
         side_in.bad = (req_depth == '0) || (int'(req_depth) > VIEW);
      end else begin
         side_in.bad = int'(req_depth) >= VIEW;
      end
      if (int'(req_column) >= MIDX) begin
         side_in.bad = 1'b1;
      end
      nu_in = NU_W'(32'(req_column) * 32'(MIDX));
      du_in = {1'b0, req_depth, 1'b0} + {1'b0, near_eff};
      nv_in = req_plane_select ? sky_num_ff : land_num_ff;
      dv_in = req_plane_select ? {1'b0, req_depth} : ({1'b0, req_depth} + DV_W'(1));
   end

   side_type           side_ff [DIV_STAGES+1];
   logic [NU_W-1:0]    nu_ff;
   logic [DU_W-1:0]    du_ff;
   logic [NUMER_W-1:0] nv_ff;
   logic [DV_W-1:0]    dv_ff;

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         side_ff[0] <= side_in;
         nu_ff      <= nu_in;
         du_ff      <= du_in;
         nv_ff      <= nv_in;
         dv_ff      <= dv_in;
      end
      for (int i = 1; i <= DIV_STAGES; i++) begin
         if (ready[i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Dividers: horizontal texel and forward texel, running side by side.
   // ------------------------------------------------------------------
   logic [NU_W-1:0]    qu;
   logic [NUMER_W-1:0] qv;

   m7ta_div_pipe #(
      .NUM_W  (NU_W),
      .DEN_W  (DU_W),
      .STAGES (DIV_STAGES)
   ) u_div_h (
      .clock (clock),
      .en    (ready[1 +: DIV_STAGES]),
      .num   (nu_ff),
      .den   (du_ff),
      .quo   (qu)
   );

   m7ta_div_pipe #(
      .NUM_W  (NUMER_W),
      .DEN_W  (DV_W),
      .STAGES (DIV_STAGES)
   ) u_div_v (
      .clock (clock),
      .en    (ready[1 +: DIV_STAGES]),
      .num   (nv_ff),
      .den   (dv_ff),
      .quo   (qv)
   );

   // ------------------------------------------------------------------
   // Preparation stage: framebuffer addresses and the texels before the wrap.
   // The sky uses a quarter of the horizontal quotient and a coarser phase.
   // ------------------------------------------------------------------
   side_type         side_last;
   logic [ROW_W-1:0] row;
   logic [NU_W-1:0]  au_in;
   logic [AV_W-1:0]  av_in;
   post_type         post_in;

   assign side_last = side_ff[DIV_STAGES];

   always_comb begin
      if (side_last.sky) begin
         row   = ROW_W'(VIEW - int'(side_last.depth));
         au_in = qu >> SKY_U_SHIFT;
         av_in = AV_W'(qv) + AV_W'(phase_ff >> SKY_PHASE_SHIFT);
      end else begin
         row   = ROW_W'(VIEW + int'(side_last.depth));
         au_in = qu;
         av_in = AV_W'(qv) + AV_W'(phase_ff >> LAND_PHASE_SHIFT);
      end
      post_in.sky         = side_last.sky;
      post_in.bad         = side_last.bad;
      post_in.frame_right = FRAME_W'(32'(row) * 32'(SCREEN_WIDTH) + 32'(MIDX)
                                     + 32'(side_last.column));
      post_in.frame_left  = FRAME_W'(32'(row) * 32'(SCREEN_WIDTH) + 32'(MIDX) - 32'd1
                                     - 32'(side_last.column));
   end

   post_type        post_ff [4];
   logic [NU_W-1:0] au_ff;
   logic [AV_W-1:0] av_ff;

   always_ff @(posedge clock) begin
      if (ready[ST_PREP]) begin
         post_ff[0] <= post_in;
         au_ff      <= au_in;
         av_ff      <= av_in;
      end
      for (int k = 1; k < 4; k++) begin
         if (ready[ST_PREP+k]) begin
            post_ff[k] <= post_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Wrap both texels into the map.
   // ------------------------------------------------------------------
   logic [MAP_W-1:0] u_wrap;
   logic [MAP_W-1:0] v_wrap;

   m7ta_mod_const #(
      .A_W     (NU_W),
      .MODULUS (MAP_SIZE)
   ) u_mod_u (
      .clock (clock),
      .en    (ready[ST_MOD0 +: 3]),
      .a     (au_ff),
      .r     (u_wrap)
   );

   m7ta_mod_const #(
      .A_W     (AV_W),
      .MODULUS (MAP_SIZE)
   ) u_mod_v (
      .clock (clock),
      .en    (ready[ST_MOD0 +: 3]),
      .a     (av_ff),
      .r     (v_wrap)
   );

   // ------------------------------------------------------------------
   // Output stage: atlas addresses. The sky map sits below the land map in the atlas,
   // and the right pixel reads the horizontally mirrored texel column.
   // ------------------------------------------------------------------
   post_type             post_last;
   logic [FRAME_W-1:0]   fr_in;
   logic [FRAME_W-1:0]   fl_in;
   logic [TEXEL_W-1:0]   tr_in;
   logic [TEXEL_W-1:0]   tl_in;
   logic [31:0]          tex_row;

   assign post_last = post_ff[3];

   always_comb begin
      tex_row = (post_last.sky ? 32'(MAP_SIZE * MAP_SIZE) : 32'd0)
                + 32'(v_wrap) * 32'(MAP_SIZE);
      if (post_last.bad) begin
         fr_in = '0;
         fl_in = '0;
         tr_in = '0;
         tl_in = '0;
      end else begin
         fr_in = post_last.frame_right;
         fl_in = post_last.frame_left;
         tr_in = TEXEL_W'(tex_row + 32'(MAP_SIZE - 1) - 32'(u_wrap));
         tl_in = TEXEL_W'(tex_row + 32'(u_wrap));
      end
   end

   logic [FRAME_W-1:0] out_fr_ff;
   logic [FRAME_W-1:0] out_fl_ff;
   logic [TEXEL_W-1:0] out_tr_ff;
   logic [TEXEL_W-1:0] out_tl_ff;
   logic               out_bad_ff;

   always_ff @(posedge clock) begin
      if (ready[ST_OUT]) begin
         out_fr_ff  <= fr_in;
         out_fl_ff  <= fl_in;
         out_tr_ff  <= tr_in;
         out_tl_ff  <= tl_in;
         out_bad_ff <= post_last.bad;
      end
   end

   assign rsp_frame_addr_right = out_fr_ff;
   assign rsp_frame_addr_left  = out_fl_ff;
   assign rsp_texel_addr_right = out_tr_ff;
   assign rsp_texel_addr_left  = out_tl_ff;
   assign rsp_request_bad      = out_bad_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // A rejected request reports all four addresses as zero.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_request_bad |->
         rsp_frame_addr_right == '0 && rsp_frame_addr_left == '0 &&
         rsp_texel_addr_right == '0 && rsp_texel_addr_left == '0)
      else $error("rejected request carries a nonzero address");

   // When the receiver takes results, the request side never stalls.
   a_flow_through: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while the response side is moving");

   // A full pipeline behind a stalled response must push back on the requester.
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && rsp_stall |-> req_stall)
      else $error("full pipeline accepted a request under a response stall");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule
